FILE: rtl/pgs_pkg.sv
// Package for the process grid split block: widths, payload structs,
// microcode opcodes, jump conditions and the control store.
// No dependencies; every other file uses it by scoped names.
package pgs_pkg;

    // Sizing of the factor list and the datapath.
    localparam int MAX_FACTORS = 16;
    localparam int PROC_BITS   = 12;
    localparam int DIM_BITS    = 24;
    localparam int CNT_W       = PROC_BITS + 1;
    localparam int OUT_W       = 13;
    localparam int IDX_W       = $clog2(MAX_FACTORS);
    localparam int FCNT_W      = $clog2(MAX_FACTORS + 1);
    localparam int LAST_IDX    = MAX_FACTORS - 1;
    localparam int SQ_W        = 2 * CNT_W;
    localparam int PROD_W      = CNT_W + DIM_BITS;
    localparam int STEP_W      = 4;

    // Request and result payloads.
    typedef struct packed {
        logic [CNT_W-1:0]    process_count;
        logic [DIM_BITS-1:0] matrix_rows;
        logic [DIM_BITS-1:0] matrix_cols;
    } t_req;

    typedef struct packed {
        logic [OUT_W-1:0] grid_rows;
        logic [OUT_W-1:0] grid_cols;
        logic             one_dropped;
    } t_rsp;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT_F,
        OP_DIV_GO,
        OP_NEXT_DIV,
        OP_PUSH_QUO,
        OP_PUSH_N,
        OP_RELOAD,
        OP_INIT_A,
        OP_PROD,
        OP_APPLY,
        OP_EMIT
    } t_op;

    // Jump conditions tested by the sequencer.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_N_LE1,
        C_SQ_GT_N,
        C_DIV_BUSY,
        C_REM_ZERO,
        C_NOT_RETRY,
        C_K_ZERO
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Status flags returned by the datapath.
    typedef struct packed {
        logic n_le1;
        logic sq_gt_n;
        logic div_busy;
        logic rem_zero;
        logic retry;
        logic k_zero;
    } t_stat;

    // Program addresses.
    localparam t_step S_IDLE   = 4'd0;
    localparam t_step S_INITF  = 4'd1;
    localparam t_step S_TEST   = 4'd2;
    localparam t_step S_SQCHK  = 4'd3;
    localparam t_step S_WAIT   = 4'd4;
    localparam t_step S_CHK    = 4'd5;
    localparam t_step S_NEXT   = 4'd6;
    localparam t_step S_HIT    = 4'd7;
    localparam t_step S_PRIME  = 4'd8;
    localparam t_step S_DROP   = 4'd9;
    localparam t_step S_RETRY  = 4'd10;
    localparam t_step S_AINIT  = 4'd11;
    localparam t_step S_ALOOP  = 4'd12;
    localparam t_step S_APPLY  = 4'd13;
    localparam t_step S_DONE   = 4'd14;

    function automatic t_uword uw(t_op op, t_cond cond, t_step target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: trial division, the prime retry, then factor placement.
    function automatic t_uword ucode_rom(t_step step);
        t_uword w;
        case (step)
            S_IDLE:  w = uw(OP_LOAD,     C_NO_START,  S_IDLE);
            S_INITF: w = uw(OP_INIT_F,   C_NEVER,     S_IDLE);
            S_TEST:  w = uw(OP_NOP,      C_N_LE1,     S_DROP);
            S_SQCHK: w = uw(OP_DIV_GO,   C_SQ_GT_N,   S_PRIME);
            S_WAIT:  w = uw(OP_NOP,      C_DIV_BUSY,  S_WAIT);
            S_CHK:   w = uw(OP_NOP,      C_REM_ZERO,  S_HIT);
            S_NEXT:  w = uw(OP_NEXT_DIV, C_ALWAYS,    S_TEST);
            S_HIT:   w = uw(OP_PUSH_QUO, C_ALWAYS,    S_TEST);
            S_PRIME: w = uw(OP_PUSH_N,   C_NEVER,     S_IDLE);
            S_DROP:  w = uw(OP_NOP,      C_NOT_RETRY, S_AINIT);
            S_RETRY: w = uw(OP_RELOAD,   C_ALWAYS,    S_INITF);
            S_AINIT: w = uw(OP_INIT_A,   C_NEVER,     S_IDLE);
            S_ALOOP: w = uw(OP_PROD,     C_K_ZERO,    S_DONE);
            S_APPLY: w = uw(OP_APPLY,    C_ALWAYS,    S_ALOOP);
            S_DONE:  w = uw(OP_EMIT,     C_ALWAYS,    S_IDLE);
            default: w = uw(OP_NOP,      C_ALWAYS,    S_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/process_grid_split.sv
// Process grid split: microcoded trial-division factoring and grid placement.
// Trial divisors run up to the square root of the count, each through the
// bit-serial divider, then each factor is placed in turn; a prime 13-bit count
// above 3 forces a second pass on the count minus one.
// One request at a time; a new request is taken in the cycle its predecessor's result
// is shown. Synchronous active-low reset idles the sequencer and clears the strobe.
module process_grid_split (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  pgs_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output pgs_pkg::t_rsp o_rsp
);

    pgs_pkg::t_uword uword;
    pgs_pkg::t_stat  stat;

    pgs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_uword (uword),
        .busy    (busy)
    );

    pgs_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_uword (uword),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: rtl/pgs_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on pgs_pkg.
module pgs_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  pgs_pkg::t_stat  i_stat,
    output pgs_pkg::t_uword o_uword,
    output logic            busy
);

    pgs_pkg::t_step r_step;
    pgs_pkg::t_step n_step;
    logic           jump;

    // Fetch the control word for the current step.
    always_comb begin
        o_uword = pgs_pkg::ucode_rom(r_step);
    end

    // Evaluate the jump condition.
    always_comb begin
        case (o_uword.cond)
            pgs_pkg::C_NEVER:     jump = 1'b0;
            pgs_pkg::C_ALWAYS:    jump = 1'b1;
            pgs_pkg::C_NO_START:  jump = !start;
            pgs_pkg::C_N_LE1:     jump = i_stat.n_le1;
            pgs_pkg::C_SQ_GT_N:   jump = i_stat.sq_gt_n;
            pgs_pkg::C_DIV_BUSY:  jump = i_stat.div_busy;
            pgs_pkg::C_REM_ZERO:  jump = i_stat.rem_zero;
            pgs_pkg::C_NOT_RETRY: jump = !i_stat.retry;
            pgs_pkg::C_K_ZERO:    jump = i_stat.k_zero;
            default:              jump = 1'b1;
        endcase
        n_step = jump ? o_uword.target : r_step + 1'b1;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pgs_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign busy = (r_step != pgs_pkg::S_IDLE);

endmodule

FILE: rtl/pgs_div.sv
// Restoring divider, one quotient bit per cycle, for the trial division.
// Depends on pgs_pkg.
module pgs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [pgs_pkg::CNT_W-1:0] i_dividend,
    input  logic [pgs_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [pgs_pkg::CNT_W-1:0] o_quo,
    output logic [pgs_pkg::CNT_W-1:0] o_rem
);

    localparam int CW = $clog2(pgs_pkg::CNT_W + 1);

    logic [CW-1:0]             r_cnt;
    logic [pgs_pkg::CNT_W-1:0] r_quo;
    logic [pgs_pkg::CNT_W-1:0] r_rem;
    logic [pgs_pkg::CNT_W-1:0] r_dsr;
    logic [pgs_pkg::CNT_W:0]   trial;
    logic                      fits;

    // Shift in the next dividend bit and test against the divisor.
    always_comb begin
        trial = {r_rem, r_quo[pgs_pkg::CNT_W-1]};
        fits  = (trial >= {1'b0, r_dsr});
    end

    // Iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= CW'(pgs_pkg::CNT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[pgs_pkg::CNT_W-2:0], fits};
            if (fits) begin
                r_rem <= pgs_pkg::CNT_W'(trial - {1'b0, r_dsr});
            end else begin
                r_rem <= pgs_pkg::CNT_W'(trial);
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/pgs_dp.sv
// Datapath: factor search registers, factor list, grid placement, result.
// Depends on pgs_pkg and pgs_div.
module pgs_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pgs_pkg::t_req   i_req,
    input  pgs_pkg::t_uword i_uword,
    output pgs_pkg::t_stat  o_stat,
    output logic            o_valid,
    output pgs_pkg::t_rsp   o_rsp
);

    logic [pgs_pkg::CNT_W-1:0]    r_procs;
    logic [pgs_pkg::DIM_BITS-1:0] r_mrows;
    logic [pgs_pkg::DIM_BITS-1:0] r_mcols;
    logic [pgs_pkg::CNT_W-1:0]    r_n;
    logic [pgs_pkg::CNT_W-1:0]    r_div;
    logic [pgs_pkg::SQ_W-1:0]     r_sq;
    logic                         r_dropped;
    logic [pgs_pkg::CNT_W-1:0]    r_list [pgs_pkg::MAX_FACTORS];
    logic [pgs_pkg::FCNT_W-1:0]   r_count;
    logic [pgs_pkg::FCNT_W-1:0]   r_k;
    logic [pgs_pkg::CNT_W-1:0]    r_grows;
    logic [pgs_pkg::CNT_W-1:0]    r_gcols;
    logic [pgs_pkg::PROD_W-1:0]   r_prod_c;
    logic [pgs_pkg::PROD_W-1:0]   r_prod_r;
    logic                         r_valid;
    pgs_pkg::t_rsp                r_rsp;

    logic                         div_go;
    logic                         div_busy;
    logic [pgs_pkg::CNT_W-1:0]    div_quo;
    logic [pgs_pkg::CNT_W-1:0]    div_rem;
    logic                         push;
    logic [pgs_pkg::CNT_W-1:0]    push_val;
    logic [pgs_pkg::FCNT_W-1:0]   k_m1;
    logic [pgs_pkg::CNT_W-1:0]    factor;

    assign div_go = (i_uword.op == pgs_pkg::OP_DIV_GO);

    pgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (r_n),
        .i_divisor  (r_div),
        .o_busy     (div_busy),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Factor to record and the factor to place next.
    always_comb begin
        push     = (i_uword.op == pgs_pkg::OP_PUSH_QUO) || (i_uword.op == pgs_pkg::OP_PUSH_N);
        push_val = (i_uword.op == pgs_pkg::OP_PUSH_N) ? r_n : r_div;
        k_m1     = r_k - 1'b1;
        factor   = r_list[k_m1[pgs_pkg::IDX_W-1:0]];
    end

    // Status flags for the sequencer.
    always_comb begin
        o_stat.n_le1    = (r_n <= pgs_pkg::CNT_W'(1));
        o_stat.sq_gt_n  = (r_sq > pgs_pkg::SQ_W'(r_n));
        o_stat.div_busy = div_busy;
        o_stat.rem_zero = (div_rem == '0);
        o_stat.retry    = (r_count == pgs_pkg::FCNT_W'(1)) &&
                          (r_procs > pgs_pkg::CNT_W'(3)) && !r_dropped;
        o_stat.k_zero   = (r_k == '0);
    end

    // Factor list; once full, further factors fold into the last entry.
    always_ff @(posedge i_clk) begin
        if (i_uword.op == pgs_pkg::OP_INIT_F) begin
            r_count <= '0;
        end else if (push) begin
            if (r_count < pgs_pkg::FCNT_W'(pgs_pkg::MAX_FACTORS)) begin
                r_list[r_count[pgs_pkg::IDX_W-1:0]] <= push_val;
                r_count <= r_count + 1'b1;
            end else begin
                r_list[pgs_pkg::IDX_W'(pgs_pkg::LAST_IDX)] <= pgs_pkg::CNT_W'(
                    r_list[pgs_pkg::IDX_W'(pgs_pkg::LAST_IDX)] * push_val);
            end
        end
    end

    // Search, retry and placement registers, driven by the current operation.
    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            pgs_pkg::OP_LOAD: begin
                r_procs   <= i_req.process_count;
                r_mrows   <= i_req.matrix_rows;
                r_mcols   <= i_req.matrix_cols;
                r_n       <= i_req.process_count;
                r_dropped <= 1'b0;
            end
            pgs_pkg::OP_INIT_F: begin
                r_div <= pgs_pkg::CNT_W'(2);
                r_sq  <= pgs_pkg::SQ_W'(4);
            end
            pgs_pkg::OP_NEXT_DIV: begin
                // (d+1)^2 = d^2 + 2d + 1
                r_div <= r_div + 1'b1;
                r_sq  <= r_sq + pgs_pkg::SQ_W'({r_div, 1'b1});
            end
            pgs_pkg::OP_PUSH_QUO: begin
                r_n <= div_quo;
            end
            pgs_pkg::OP_PUSH_N: begin
                r_n <= pgs_pkg::CNT_W'(1);
            end
            pgs_pkg::OP_RELOAD: begin
                r_n       <= r_procs - 1'b1;
                r_dropped <= 1'b1;
            end
            pgs_pkg::OP_INIT_A: begin
                r_grows <= pgs_pkg::CNT_W'(1);
                r_gcols <= pgs_pkg::CNT_W'(1);
                r_k     <= r_count;
            end
            pgs_pkg::OP_PROD: begin
                r_prod_c <= r_grows * r_mcols;
                r_prod_r <= r_mrows * r_gcols;
            end
            pgs_pkg::OP_APPLY: begin
                // Columns take the factor while rows/cols is at or above the matrix ratio.
                if (r_prod_c >= r_prod_r) begin
                    r_gcols <= pgs_pkg::CNT_W'(r_gcols * factor);
                end else begin
                    r_grows <= pgs_pkg::CNT_W'(r_grows * factor);
                end
                r_k <= k_m1;
            end
            default: begin
            end
        endcase
    end

    // Result register and its one-cycle strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_uword.op == pgs_pkg::OP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.op == pgs_pkg::OP_EMIT) begin
            r_rsp.grid_rows   <= pgs_pkg::OUT_W'(r_grows);
            r_rsp.grid_cols   <= pgs_pkg::OUT_W'(r_gcols);
            r_rsp.one_dropped <= r_dropped;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

FILE: dv/process_grid_split_test.sv
// Self-checking testbench for process_grid_split: directed and random requests,
// each result checked against a typed-in answer or a built-in grid predictor.
// Depends on pgs_pkg and process_grid_split from the rtl folder.
module process_grid_split_test;

    localparam int N_DIRECTED   = 23;
    localparam int N_RANDOM     = 117;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_DIM      = 24'hFFFFFF;
    localparam int MAX_COUNT    = 8191;

    // One row of the directed table; the result is typed in only when known is set.
    typedef struct {
        pgs_pkg::t_req req;
        bit            known;
        pgs_pkg::t_rsp rsp;
    } t_plan_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    pgs_pkg::t_req i_req;
    logic          busy;
    logic          o_valid;
    pgs_pkg::t_rsp o_rsp;

    // Expectation attached to the request currently on the bus.
    bit            pending_known;
    pgs_pkg::t_rsp pending_rsp;

    pgs_pkg::t_rsp grid_expect_q[$];
    int            grid_errors;
    int            stall_cycles;

    t_plan_row dir_plan [N_DIRECTED];

    process_grid_split u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Trial division with the divisor carried across hits, capped list length.
    function automatic void prime_factors(input int unsigned n,
                                          output int unsigned fac[$]);
        int unsigned d;
        d = 2;
        fac = {};
        while (n > 1) begin
            while ((n % d) != 0) d++;
            if (fac.size() < pgs_pkg::MAX_FACTORS) begin
                fac.push_back(d);
            end else begin
                fac[pgs_pkg::MAX_FACTORS-1] = fac[pgs_pkg::MAX_FACTORS-1] * d;
            end
            n = n / d;
        end
    endfunction

    // Grid choice: factor the count (or count - 1 for a prime above 3), then place
    // factors largest first by the cross-product ratio test.
    function automatic pgs_pkg::t_rsp grid_for_request(input pgs_pkg::t_req r);
        int unsigned     fac[$];
        int unsigned     procs;
        longint unsigned grows;
        longint unsigned gcols;
        longint unsigned mrows;
        longint unsigned mcols;
        pgs_pkg::t_rsp   p;
        procs = 32'(r.process_count);
        mrows = 64'(r.matrix_rows);
        mcols = 64'(r.matrix_cols);
        grows = 1;
        gcols = 1;
        p.one_dropped = 1'b0;
        prime_factors(procs, fac);
        if (fac.size() == 1 && procs > 3) begin
            prime_factors(procs - 1, fac);
            p.one_dropped = 1'b1;
        end
        for (int k = fac.size(); k > 0; k--) begin
            if (grows * mcols >= mrows * gcols) begin
                gcols = gcols * fac[k-1];
            end else begin
                grows = grows * fac[k-1];
            end
        end
        p.grid_rows = grows[pgs_pkg::OUT_W-1:0];
        p.grid_cols = gcols[pgs_pkg::OUT_W-1:0];
        return p;
    endfunction

    function automatic t_plan_row plan_row(input int cnt, input int rows, input int cols,
                                           input bit known, input int gr, input int gc,
                                           input bit dropped);
        t_plan_row pr;
        pr.req.process_count = cnt[pgs_pkg::CNT_W-1:0];
        pr.req.matrix_rows   = rows[pgs_pkg::DIM_BITS-1:0];
        pr.req.matrix_cols   = cols[pgs_pkg::DIM_BITS-1:0];
        pr.known             = known;
        pr.rsp.grid_rows     = gr[pgs_pkg::OUT_W-1:0];
        pr.rsp.grid_cols     = gc[pgs_pkg::OUT_W-1:0];
        pr.rsp.one_dropped   = dropped;
        return pr;
    endfunction

    // Random request: mostly legal counts, with primes, powers of two and the
    // full 13-bit range mixed in; matrix shapes from full range to degenerate.
    function automatic pgs_pkg::t_req random_request();
        int unsigned   primes [8] = '{5, 7, 13, 97, 127, 1021, 4093, 8191};
        int unsigned   sel;
        pgs_pkg::t_req r;
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            r.process_count = pgs_pkg::CNT_W'($urandom_range(1, 4096));
        end else if (sel == 6) begin
            r.process_count = pgs_pkg::CNT_W'($urandom_range(0, 16));
        end else if (sel == 7) begin
            r.process_count = pgs_pkg::CNT_W'(primes[$urandom_range(0, 7)]);
        end else if (sel == 8) begin
            r.process_count = 13'd1 << $urandom_range(0, 12);
        end else begin
            r.process_count = pgs_pkg::CNT_W'($urandom_range(0, MAX_COUNT));
        end
        sel = $urandom_range(0, 9);
        if (sel <= 4) begin
            r.matrix_rows = pgs_pkg::DIM_BITS'($urandom_range(0, MAX_DIM));
            r.matrix_cols = pgs_pkg::DIM_BITS'($urandom_range(0, MAX_DIM));
        end else if (sel <= 7) begin
            r.matrix_rows = pgs_pkg::DIM_BITS'($urandom_range(1, 64));
            r.matrix_cols = pgs_pkg::DIM_BITS'($urandom_range(1, 64));
        end else if (sel == 8) begin
            r.matrix_rows = $urandom_range(0, 1) ? '0 :
                            pgs_pkg::DIM_BITS'($urandom_range(0, MAX_DIM));
            r.matrix_cols = $urandom_range(0, 1) ? '0 :
                            pgs_pkg::DIM_BITS'($urandom_range(0, 3));
        end else begin
            r.matrix_rows = $urandom_range(0, 1) ? pgs_pkg::DIM_BITS'(MAX_DIM) :
                            pgs_pkg::DIM_BITS'(1);
            r.matrix_cols = $urandom_range(0, 1) ? pgs_pkg::DIM_BITS'(MAX_DIM) :
                            pgs_pkg::DIM_BITS'(1);
        end
        return r;
    endfunction

    task automatic report_failure(input string what);
        if (grid_errors < 10) $display("ERROR: %s", what);
        grid_errors++;
    endtask

    // Drive one request after a gap and hold it until busy drops; returns at a falling edge.
    task automatic send_request(input pgs_pkg::t_req r, input bit known,
                                input pgs_pkg::t_rsp rsp, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_req         <= r;
        pending_known <= known;
        pending_rsp   <= rsp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result checking and request capture at the rising edge.
    always @(posedge i_clk) begin
        pgs_pkg::t_rsp want;
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            if (o_valid) begin
                if (grid_expect_q.size() == 0) begin
                    report_failure($sformatf(
                        "result %0d x %0d drop %0b with no request waiting",
                        o_rsp.grid_rows, o_rsp.grid_cols, o_rsp.one_dropped));
                end else begin
                    want = grid_expect_q.pop_front();
                    if (o_rsp.grid_rows !== want.grid_rows
                        || o_rsp.grid_cols !== want.grid_cols
                        || o_rsp.one_dropped !== want.one_dropped) begin
                        report_failure($sformatf(
                            "expected %0d x %0d drop %0b, got %0d x %0d drop %0b",
                            want.grid_rows, want.grid_cols, want.one_dropped,
                            o_rsp.grid_rows, o_rsp.grid_cols, o_rsp.one_dropped));
                    end
                end
            end
            if (start && !busy) begin
                grid_expect_q.push_back(pending_known ? pending_rsp : grid_for_request(i_req));
            end
            if (o_valid || (start && !busy)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Watchdog on cycles with neither a request nor a result moving.
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("process_grid_split_test failed");
        $finish;
    end

    // Main sequence: reset, directed table, random requests, drain.
    initial begin
        int            gap;
        pgs_pkg::t_rsp none;
        none          = '0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req         = '0;
        pending_known = 1'b0;
        pending_rsp   = '0;

        // Directed table: known answers for degenerate counts, small primes, the prime
        // retry, power-of-two extremes and zero matrix dimensions, then predicted rows.
        dir_plan = '{
            plan_row(0,    1,       1,       1, 1,    1,    0),
            plan_row(1,    MAX_DIM, MAX_DIM, 1, 1,    1,    0),
            plan_row(2,    1,       1,       1, 1,    2,    0),
            plan_row(3,    5,       1,       1, 3,    1,    0),
            plan_row(5,    1,       1,       1, 2,    2,    1),
            plan_row(4096, 1,       1,       1, 64,   64,   0),
            plan_row(4096, MAX_DIM, 1,       1, 4096, 1,    0),
            plan_row(4096, 1,       MAX_DIM, 1, 1,    4096, 0),
            plan_row(12,   7,       0,       1, 12,   1,    0),
            plan_row(12,   0,       0,       1, 1,    12,   0),
            plan_row(7,    0,       0,       1, 1,    6,    1),
            plan_row(1,    0,       0,       1, 1,    1,    0),
            plan_row(3,    0,       1,       1, 1,    3,    0),
            plan_row(4,    0,       5,       1, 1,    4,    0),
            plan_row(2,    MAX_DIM, MAX_DIM - 1, 1, 2, 1,   0),
            plan_row(8191, 1,       1,       0, 0,    0,    0),
            plan_row(8190, 3,       2,       0, 0,    0,    0),
            plan_row(4097, 100,     1,       0, 0,    0,    0),
            plan_row(6,    2,       3,       0, 0,    0,    0),
            plan_row(97,   1000,    10,      0, 0,    0,    0),
            plan_row(4093, 1,       7,       0, 0,    0,    0),
            plan_row(4095, MAX_DIM, MAX_DIM, 0, 0,    0,    0),
            plan_row(6144, 1,       1,       0, 0,    0,    0)
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            gap = $urandom_range(0, 19);
            send_request(dir_plan[i].req, dir_plan[i].known, dir_plan[i].rsp, gap);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            gap = $urandom_range(0, 19);
            send_request(random_request(), 1'b0, none, gap);
        end
        start <= 1'b0;

        while (grid_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (grid_errors == 0) begin
            $display("process_grid_split_test passed");
        end else begin
            $display("process_grid_split_test failed");
        end
        $finish;
    end

endmodule
